FILE: sv/ppd_pkg.sv
// shared types and constants of the pairwise point distance block
// used by ppd_ctrl, ppd_datapath and pairwise_point_distance; no dependencies
package ppd_pkg;

    // fixed field widths of the transaction payloads
    localparam int IDX_W   = 10;
    localparam int COORD_W = 16;
    localparam int DIST_W  = 25;

    // defaults for the top level parameters
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 8;

    // operation codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // axis select codes for the shared multiplier
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          first_index;
        logic [IDX_W-1:0]          second_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  row_point;
        logic [IDX_W-1:0]  column_point;
    } t_out_item;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       store;      // write the incoming point
        logic       capture;    // take the indices of a query
        logic       rd_col;     // read address is the column point
        logic       latch_p;    // row point data is on the read port
        logic       latch_q;    // column point data is on the read port
        logic       mul_en;     // square one axis difference
        logic [1:0] axis;
        logic       acc_en;     // add the last square into the sum
        logic       root_load;  // start the square root
        logic       root_step;  // one square root iteration
        logic       out_load;   // move the result to the output register
    } t_ppd_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_busy;         // output register full and stalled
    } t_ppd_status;

endpackage

FILE: sv/ppd_ctrl.sv
// controller state machine of the pairwise point distance block
// depends on ppd_pkg; drives the command struct of ppd_datapath
module ppd_ctrl #(
    parameter int COORD_BITS = ppd_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = ppd_pkg::DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_op,
    output logic                 o_in_stall,
    input  ppd_pkg::t_ppd_status i_status,
    output ppd_pkg::t_ppd_cmd    o_cmd
);
    import ppd_pkg::*;

    // one square root iteration per result bit
    localparam int STEPS  = COORD_BITS + 2 + FRAC_BITS;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ROW,
        S_RD_COL,
        S_LATCH_Q,
        S_MUL,
        S_ACC,
        S_LOAD,
        S_ROOT,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_axis, n_axis;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_idle_take;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_idle_take = (r_state == S_IDLE) && i_in_valid;

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_idle_take && (i_in_op == OP_QUERY)) begin
                    n_state = S_RD_ROW;
                end
            end
            S_RD_ROW:  n_state = S_RD_COL;
            S_RD_COL:  n_state = S_LATCH_Q;
            S_LATCH_Q: begin
                n_state = S_MUL;
                n_axis  = AXIS_X;
            end
            S_MUL: begin
                if (r_axis == AXIS_Z) begin
                    n_state = S_ACC;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_ACC:  n_state = S_LOAD;
            S_LOAD: begin
                n_state = S_ROOT;
                n_step  = STEP_W'(STEPS - 1);
            end
            S_ROOT: begin
                if (r_step == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.store     = w_idle_take && (i_in_op == OP_STORE);
        o_cmd.capture   = w_idle_take && (i_in_op == OP_QUERY);
        o_cmd.rd_col    = (r_state == S_RD_COL);
        o_cmd.latch_p   = (r_state == S_RD_COL);
        o_cmd.latch_q   = (r_state == S_LATCH_Q);
        o_cmd.mul_en    = (r_state == S_MUL);
        o_cmd.axis      = r_axis;
        o_cmd.acc_en    = (r_state == S_MUL) || (r_state == S_ACC);
        o_cmd.root_load = (r_state == S_LOAD);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.out_load  = (r_state == S_DONE) && !i_status.out_busy;
    end

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AXIS_X;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_step  <= n_step;
        end
    end

endmodule

FILE: sv/ppd_datapath.sv
// datapath of the pairwise point distance block: point memory, shared
// squarer, sum, bit-serial square root and output register; depends on ppd_pkg
module ppd_datapath #(
    parameter int MAX_POINTS = ppd_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = ppd_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = ppd_pkg::DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppd_pkg::t_ppd_cmd    i_cmd,
    output ppd_pkg::t_ppd_status o_status,
    input  ppd_pkg::t_in_item    i_in_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output ppd_pkg::t_out_item   o_out_data
);
    import ppd_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int PT_W   = 3 * CB;
    localparam int MAG_W  = CB + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SUM_W  = 2 * CB + 4;
    localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [PT_W-1:0]   r_mem [MAX_POINTS];
    logic [PT_W-1:0]   r_rdata;
    logic [PT_W-1:0]   r_p, r_q;
    logic [IDX_W-1:0]  r_row, r_col;
    logic              r_row_ok, r_col_ok, r_same;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_sum;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [AW+IDX_W-1:0]     w_in_ext, w_row_ext, w_col_ext;
    logic [AW-1:0]           w_wr_addr, w_rd_addr;
    logic                    w_in_ok;
    logic [PT_W-1:0]         w_wr_pt;
    logic [CB-1:0]           w_pa, w_qa;
    logic signed [CB:0]      w_diff;
    logic [MAG_W-1:0]        w_mag;
    logic [REM_W-1:0]        w_rem_sh, w_trial;
    logic [DIST_W+ROOT_W-1:0] w_dist_ext;

    // coordinate taken as its low bits, sign-extended where the store is wider
    function automatic logic [CB-1:0] fit_coord(input logic [COORD_W-1:0] c);
        logic [COORD_W+CB-1:0] ext;
        ext = {{CB{c[COORD_W-1]}}, c};
        return ext[CB-1:0];
    endfunction

    // address and range of the incoming index and the query indices
    assign w_in_ext  = (AW+IDX_W)'(i_in_data.first_index);
    assign w_row_ext = (AW+IDX_W)'(r_row);
    assign w_col_ext = (AW+IDX_W)'(r_col);
    assign w_wr_addr = w_in_ext[AW-1:0];
    assign w_rd_addr = i_cmd.rd_col ? w_col_ext[AW-1:0] : w_row_ext[AW-1:0];
    assign w_in_ok   = (32'(i_in_data.first_index) < MAX_POINTS);
    assign w_wr_pt   = {fit_coord(i_in_data.coord_z), fit_coord(i_in_data.coord_y),
                        fit_coord(i_in_data.coord_x)};

    // point memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_in_ok) begin
            r_mem[w_wr_addr] <= w_wr_pt;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // query indices and both points
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row    <= i_in_data.first_index;
            r_col    <= i_in_data.second_index;
            r_row_ok <= w_in_ok;
            r_col_ok <= (32'(i_in_data.second_index) < MAX_POINTS);
            r_same   <= (i_in_data.first_index == i_in_data.second_index);
        end
        if (i_cmd.latch_p) begin
            r_p <= r_row_ok ? r_rdata : '0;
        end
        if (i_cmd.latch_q) begin
            r_q <= r_col_ok ? r_rdata : '0;
        end
    end

    // axis select and absolute difference
    always_comb begin
        case (i_cmd.axis)
            AXIS_X: begin
                w_pa = r_p[0 +: CB];
                w_qa = r_q[0 +: CB];
            end
            AXIS_Y: begin
                w_pa = r_p[CB +: CB];
                w_qa = r_q[CB +: CB];
            end
            AXIS_Z: begin
                w_pa = r_p[2*CB +: CB];
                w_qa = r_q[2*CB +: CB];
            end
            default: begin
                w_pa = '0;
                w_qa = '0;
            end
        endcase
    end

    assign w_diff = $signed({w_pa[CB-1], w_pa}) - $signed({w_qa[CB-1], w_qa});
    assign w_mag  = w_diff[CB] ? MAG_W'(-w_diff) : MAG_W'(w_diff);

    // shared squarer and sum of squares
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cmd.mul_en) begin
                r_prod <= w_mag * w_mag;
            end
            if (i_cmd.acc_en) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
        end
    end

    // one result bit per iteration, two radicand bits brought down each time
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_load) begin
            r_rad  <= r_same ? '0 : (RAD_W'(r_sum) << (2 * FRAC_BITS));
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= r_rad << 2;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // output register
    assign w_dist_ext = (DIST_W+ROOT_W)'(r_root);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.distance     <= w_dist_ext[DIST_W-1:0];
            r_out.row_point    <= r_row;
            r_out.column_point <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_status.out_busy = r_out_valid && i_out_stall;

endmodule

FILE: sv/pairwise_point_distance.sv
// top level of the pairwise point distance block
// depends on ppd_pkg, ppd_ctrl and ppd_datapath
//
// Stores 3D points with signed coordinates and returns the floored Euclidean
// distance between two stored points, with FRAC_BITS fractional bits. A store
// transaction writes one point and is taken every cycle while no query is in
// progress, with no result. A query transaction returns one result; the block
// accepts nothing else from the query's acceptance until it has finished. A
// query passes through the two reads from the single read port of the point
// memory, the one multiplier shared by the three axes and the bit-serial
// square root (one result bit per cycle). A finished result moves to an
// output register once that register is not full and stalled, and the next
// item is accepted while it waits there. Querying a point never written since
// reset gives an unspecified distance; equal indices give zero, and an index
// at or beyond MAX_POINTS is not stored and reads as the origin.
module pairwise_point_distance #(
    parameter int MAX_POINTS = ppd_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = ppd_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = ppd_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ppd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ppd_pkg::t_out_item o_out_data
);
    import ppd_pkg::*;

    t_ppd_cmd    w_cmd;
    t_ppd_status w_status;

    ppd_ctrl #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ppd_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a query holds off the input side on the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == OP_QUERY) |=> o_in_stall)
        else $error("query accepted but input side not held off");

    // a store leaves the block ready for the next transaction
    a_store_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == OP_STORE) |=> !o_in_stall)
        else $error("store transaction stalled the input side");

    // a new result only appears at the end of a query
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a query in progress");

    // the diagonal of the matrix is zero
    a_diag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.row_point == o_out_data.column_point)
        |-> (o_out_data.distance == '0))
        else $error("nonzero distance for equal indices");

endmodule
